FILE: hw/rtl/pff_pkg.sv
// Shared constants, widths, item types and helpers for the friction force block.
package pff_pkg;

  localparam int FRAC_BITS = 16;

  localparam int MASS_W = 31;
  localparam int VEL_W  = 32;
  localparam int MU_W   = 20;
  localparam int G_W    = 24;
  localparam int IDX_W  = 2;
  localparam int CFG_W  = 24;

  localparam int NORM_W  = MASS_W + G_W - FRAC_BITS;
  localparam int LIMIT_W = MU_W + NORM_W - FRAC_BITS;
  localparam int LO_W    = LIMIT_W / 2;
  localparam int HI_W    = LIMIT_W - LO_W;
  localparam int PROD_W  = LIMIT_W + VEL_W;
  localparam int SUM_W   = 2 * VEL_W;
  localparam int ROOT_W  = VEL_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int QUO_W   = VEL_W - 1;
  localparam int CMP_W   = (LIMIT_W > ROOT_W) ? LIMIT_W : ROOT_W;
  localparam int DCMP_W  = (PROD_W > ROOT_W + QUO_W) ? PROD_W : ROOT_W + QUO_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [IDX_W-1:0] CFG_MODE = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_MU   = IDX_W'(1);
  localparam logic [IDX_W-1:0] CFG_G    = IDX_W'(2);

  localparam logic MODE_STATIC = 1'b0;

  localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};

  // Classified particle as it leaves the front end.
  typedef struct packed {
    logic                   inf;
    logic                   vzero;
    logic [2:0]             neg;
    logic [2:0][VEL_W-1:0]  mag;
    logic [NORM_W-1:0]      normal;
  } pff_item_t;

  // Per-particle context carried down the arithmetic pipeline.
  typedef struct packed {
    logic                   inf;
    logic                   vzero;
    logic [2:0]             neg;
    logic [2:0][VEL_W-1:0]  mag;
    logic [LIMIT_W-1:0]     limit;
  } pff_ctx_t;

  // Applies a magnitude (at most 2^31) against the sign of the velocity, saturating.
  function automatic logic [VEL_W-1:0] pff_force(input logic neg, input logic [VEL_W-1:0] c);
    logic [VEL_W-1:0] r;
    if (neg) begin
      r = (c == VEL_MIN) ? VEL_MAX : c;
    end else begin
      r = VEL_W'(0) - c;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/pff_front.sv
// Front end: accepts particles, takes velocity magnitudes and the normal force.
module pff_front
  import pff_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [127:0]          s_tdata,
  input  logic                  s_tuser,
  input  logic [G_W-1:0]        gravity_accel,
  output logic                  item_valid,
  output pff_item_t             item,
  input  logic                  q_full
);

  logic                        accept;
  logic                        push;
  logic [MASS_W-1:0]           mass;
  logic [2:0][VEL_W-1:0]       vel;
  logic [MASS_W+G_W-1:0]       weight;
  pff_item_t                   item_next;

  assign push     = item_valid && !q_full;
  assign s_tready = !item_valid || !q_full;
  assign accept   = s_tvalid && s_tready;

  assign mass   = s_tdata[MASS_W-1:0];
  assign vel[0] = s_tdata[MASS_W +: VEL_W];
  assign vel[1] = s_tdata[MASS_W+VEL_W +: VEL_W];
  assign vel[2] = s_tdata[MASS_W+2*VEL_W +: VEL_W];
  assign weight = (MASS_W+G_W)'(mass) * (MASS_W+G_W)'(gravity_accel);

  always_comb begin
    item_next.inf    = s_tuser;
    item_next.normal = weight[MASS_W+G_W-1:FRAC_BITS];
    for (int i = 0; i < 3; i++) begin
      item_next.neg[i] = vel[i][VEL_W-1];
      item_next.mag[i] = vel[i][VEL_W-1] ? (VEL_W'(0) - vel[i]) : vel[i];
    end
    item_next.vzero = (vel[0] == '0) && (vel[1] == '0) && (vel[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (push) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

FILE: hw/rtl/pff_queue.sv
// Short queue of classified particles between the front end and the arithmetic pipeline.
module pff_queue
  import pff_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pff_item_t  push_item,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output pff_item_t  head
);

  pff_item_t           slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full      = (count == (QPTR_W+1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: hw/rtl/pff_back.sv
// Back end: friction limit, pipelined square root and divider, and the result register.
module pff_back
  import pff_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  pff_item_t        q_item,
  output logic             pop,
  input  logic             friction_mode,
  input  logic [MU_W-1:0]  friction_coefficient,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [95:0]      m_tdata,
  output logic             m_tuser
);

  logic adv;
  assign adv = !m_tvalid || m_tready;
  assign pop = adv && q_valid;

  // Limit and squares.
  logic [MU_W+NORM_W-1:0]      limit_full;
  logic                        s0_vld;
  pff_ctx_t                    s0_ctx;
  logic [2:0][SUM_W-1:0]       s0_sq;

  assign limit_full = (MU_W+NORM_W)'(friction_coefficient) * (MU_W+NORM_W)'(q_item.normal);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ctx.inf   <= q_item.inf;
      s0_ctx.vzero <= q_item.vzero;
      s0_ctx.neg   <= q_item.neg;
      s0_ctx.mag   <= q_item.mag;
      s0_ctx.limit <= limit_full[MU_W+NORM_W-1:FRAC_BITS];
      for (int i = 0; i < 3; i++) begin
        s0_sq[i] <= SUM_W'(q_item.mag[i]) * SUM_W'(q_item.mag[i]);
      end
    end
  end

  // Sum of squares and split products of limit and magnitude.
  logic                          s1_vld;
  pff_ctx_t                      s1_ctx;
  logic [SUM_W-1:0]              s1_sum;
  logic [2:0][LO_W+VEL_W-1:0]    s1_pl;
  logic [2:0][HI_W+VEL_W-1:0]    s1_ph;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= s0_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctx <= s0_ctx;
      s1_sum <= s0_sq[0] + s0_sq[1] + s0_sq[2];
      for (int i = 0; i < 3; i++) begin
        s1_pl[i] <= (LO_W+VEL_W)'(s0_ctx.limit[LO_W-1:0]) * (LO_W+VEL_W)'(s0_ctx.mag[i]);
        s1_ph[i] <= (HI_W+VEL_W)'(s0_ctx.limit[LIMIT_W-1:LO_W]) * (HI_W+VEL_W)'(s0_ctx.mag[i]);
      end
    end
  end

  // Square root, one result bit per stage.
  logic                      rt_vld  [0:ROOT_W];
  pff_ctx_t                  rt_ctx  [0:ROOT_W];
  logic [2:0][PROD_W-1:0]    rt_p    [0:ROOT_W];
  logic [SUM_W-1:0]          rt_n    [0:ROOT_W];
  logic [REM_W-1:0]          rt_rem  [0:ROOT_W];
  logic [ROOT_W-1:0]         rt_root [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_vld[0] <= 1'b0;
    end else if (adv) begin
      rt_vld[0] <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rt_ctx[0]  <= s1_ctx;
      rt_n[0]    <= s1_sum;
      rt_rem[0]  <= '0;
      rt_root[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        rt_p[0][i] <= (PROD_W'(s1_ph[i]) << LO_W) + PROD_W'(s1_pl[i]);
      end
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;

    assign t     = {rt_rem[k], rt_n[k][SUM_W-1 -: 2]};
    assign trial = {2'b00, rt_root[k], 2'b01};
    assign diff  = t - trial;
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_vld[k+1] <= 1'b0;
      end else if (adv) begin
        rt_vld[k+1] <= rt_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_ctx[k+1]  <= rt_ctx[k];
        rt_p[k+1]    <= rt_p[k];
        rt_n[k+1]    <= rt_n[k] << 2;
        rt_rem[k+1]  <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
        rt_root[k+1] <= {rt_root[k][ROOT_W-2:0], ge};
      end
    end
  end

  // Divider: overflow check first, then one quotient bit per stage.
  logic [ROOT_W-1:0]           speed;
  logic [CMP_W-1:0]            speed_c;
  logic [CMP_W-1:0]            limit_c;
  logic [DCMP_W-1:0]           dcap;
  logic [2:0][DCMP_W-1:0]      p_ext;

  logic                        dv_vld   [0:QUO_W];
  pff_ctx_t                    dv_ctx   [0:QUO_W];
  logic [ROOT_W-1:0]           dv_speed [0:QUO_W];
  logic                        dv_stat  [0:QUO_W];
  logic [2:0]                  dv_ovf   [0:QUO_W];
  logic [2:0][ROOT_W-1:0]      dv_rem   [0:QUO_W];
  logic [2:0][QUO_W-1:0]       dv_low   [0:QUO_W];
  logic [2:0][QUO_W-1:0]       dv_q     [0:QUO_W];

  assign speed   = rt_root[ROOT_W];
  assign speed_c = CMP_W'(speed);
  assign limit_c = CMP_W'(rt_ctx[ROOT_W].limit);
  assign dcap    = DCMP_W'(speed) << QUO_W;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_ext[i] = DCMP_W'(rt_p[ROOT_W][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= rt_vld[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_ctx[0]   <= rt_ctx[ROOT_W];
      dv_speed[0] <= speed;
      dv_stat[0]  <= (speed_c < limit_c);
      dv_q[0]     <= '0;
      for (int i = 0; i < 3; i++) begin
        dv_ovf[0][i] <= (p_ext[i] >= dcap);
        dv_rem[0][i] <= p_ext[i][QUO_W +: ROOT_W];
        dv_low[0][i] <= p_ext[i][QUO_W-1:0];
      end
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [2:0][ROOT_W:0] t;
    logic [2:0][ROOT_W:0] diff;
    logic [2:0]           ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]    = {dv_rem[k][i], dv_low[k][i][QUO_W-1]};
        diff[i] = t[i] - {1'b0, dv_speed[k]};
        ge[i]   = (t[i] >= {1'b0, dv_speed[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else if (adv) begin
        dv_vld[k+1] <= dv_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_ctx[k+1]   <= dv_ctx[k];
        dv_speed[k+1] <= dv_speed[k];
        dv_stat[k+1]  <= dv_stat[k];
        dv_ovf[k+1]   <= dv_ovf[k];
        for (int i = 0; i < 3; i++) begin
          dv_rem[k+1][i] <= ge[i] ? diff[i][ROOT_W-1:0] : t[i][ROOT_W-1:0];
          dv_low[k+1][i] <= dv_low[k][i] << 1;
          dv_q[k+1][i]   <= {dv_q[k][i][QUO_W-2:0], ge[i]};
        end
      end
    end
  end

  // Result selection and output register.
  logic                    applied;
  logic [2:0][VEL_W-1:0]   mag_sel;
  logic [2:0][VEL_W-1:0]   force_v;

  always_comb begin
    if (friction_mode == MODE_STATIC) begin
      applied = !dv_ctx[QUO_W].inf && dv_stat[QUO_W];
    end else begin
      applied = !dv_ctx[QUO_W].inf && !dv_ctx[QUO_W].vzero;
    end
    for (int i = 0; i < 3; i++) begin
      if (friction_mode == MODE_STATIC) begin
        mag_sel[i] = dv_ctx[QUO_W].mag[i];
      end else if (dv_ovf[QUO_W][i]) begin
        mag_sel[i] = VEL_MIN;
      end else begin
        mag_sel[i] = {1'b0, dv_q[QUO_W][i]};
      end
      force_v[i] = applied ? pff_force(dv_ctx[QUO_W].neg[i], mag_sel[i]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dv_vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tuser <= applied;
      m_tdata <= {force_v[2], force_v[1], force_v[0]};
    end
  end

endmodule

FILE: hw/rtl/particle_friction_force.sv
// Top level of the Coulomb friction force block: configuration registers and the three parts.
//
// Each input item on the s_ channel is one particle; each produces exactly one result item
// on the m_ channel, in order. The result carries force_applied in m_tuser and the three
// saturated force components in m_tdata.
// From the accepting edge to m_tvalid an item passes the front register, the queue,
// three set-up stages, 32 square root stages, one compare stage and 31 divider stages,
// then the result register; the front register loads at the accepting edge itself.
// Throughput is one item per cycle unless the pipeline is held; the square root and the
// divider produce one bit per stage, so each stage takes a new particle every cycle too.
// A four-entry queue lets the front end keep accepting while the pipeline is held.
// When the receiver stalls, the whole arithmetic pipeline holds; s_tready falls only
// once the queue and the front register are both full.
// Configuration is written through cfg_we, cfg_index and cfg_data, by the user only while no
// item is in flight (not enforced by the block); indexes beyond the register list are ignored.
// Reset is synchronous: the pipeline and queue empty at once and the registers return to
// kinetic mode, a coefficient of 0.5 and a gravity of about 9.81.
module particle_friction_force
  import pff_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [127:0]      s_tdata,   // particle_mass, vel_x, vel_y, vel_z, zero pad
  input  logic              s_tuser,   // mass_infinite
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [95:0]       m_tdata,   // force_x, force_y, force_z
  output logic              m_tuser,   // force_applied
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic              friction_mode;
  logic [MU_W-1:0]   friction_coefficient;
  logic [G_W-1:0]    gravity_accel;

  logic              f_valid;
  pff_item_t         f_item;
  logic              q_full;
  logic              q_push;
  logic              q_valid;
  logic              q_pop;
  pff_item_t         q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      friction_mode        <= 1'b1;
      friction_coefficient <= MU_W'(32768);
      gravity_accel        <= G_W'(642908);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE: friction_mode        <= cfg_data[0];
        CFG_MU:   friction_coefficient <= cfg_data[MU_W-1:0];
        CFG_G:    gravity_accel        <= cfg_data[G_W-1:0];
        default: ;
      endcase
    end
  end

  assign q_push = f_valid && !q_full;

  pff_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .gravity_accel (gravity_accel),
    .item_valid    (f_valid),
    .item          (f_item),
    .q_full        (q_full)
  );

  pff_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  pff_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .q_valid              (q_valid),
    .q_item               (q_head),
    .pop                  (q_pop),
    .friction_mode        (friction_mode),
    .friction_coefficient (friction_coefficient),
    .m_tvalid             (m_tvalid),
    .m_tready             (m_tready),
    .m_tdata              (m_tdata),
    .m_tuser              (m_tuser)
  );

  // A result with no force carries all-zero components.
  a_no_force_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("result without force has nonzero components");

  // Input back-pressure only comes from a full queue behind a held front register.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_full && f_valid)
    else $error("s_tready low while the queue has room");

  // The pipeline is empty straight after a reset edge.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !q_valid)
    else $error("pipeline not empty after reset");

endmodule
